// ----- hdl/ambient_backlight_slew_control_top_assert.svh -----
// assertion macros for the backlight slew block
`ifndef AMBIENT_BACKLIGHT_SLEW_CONTROL_TOP_ASSERT_SVH
`define AMBIENT_BACKLIGHT_SLEW_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define ABSLC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ABSLC_ASSERT(label, prop, msg) \
  `ABSLC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define ABSLC_ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ABSLC_ASSERT(label, prop, msg)

`endif

`endif

// ----- hdl/abslc_pkg.sv -----
`timescale 1ns / 1ps

package abslc_pkg;

  localparam int MENU_LEVELS = 16;
  localparam int MAX_POINTS  = 4;
  localparam int ROW_LEN     = MAX_POINTS + 1;
  localparam int MAP_DEPTH   = MENU_LEVELS * ROW_LEN;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);

  localparam int OUTPUT_BITS = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int LEVEL_W     = 4;
  localparam int BAND_W      = 3;
  localparam int POINTS_W    = 3;
  localparam int THR_W       = 16;
  localparam int NUM_THR     = 4;
  localparam int ACTION_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int LVL_IDX_W = (MENU_LEVELS > 1) ? $clog2(MENU_LEVELS) : 1;
  localparam int LVL_EXT_W = ((LVL_IDX_W > LEVEL_W) ? LVL_IDX_W : LEVEL_W) + 1;

  localparam logic [LEVEL_W-1:0]     MENU_LEVEL_RESET = LEVEL_W'(5);
  localparam logic [POINTS_W-1:0]    POINTS_RESET     = POINTS_W'(4);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_LEVEL = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR0   = 3'd0,
    CFG_THR1   = 3'd1,
    CFG_THR2   = 3'd2,
    CFG_THR3   = 3'd3,
    CFG_POINTS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                 force_jump;
    logic [BAND_W-1:0]    band;
    logic [LEVEL_W-1:0]   level;
  } meas_t;

  typedef struct packed {
    logic                   we;
    logic [MAP_AW-1:0]      waddr;
    logic [OUTPUT_BITS-1:0] wdata;
    logic                   re;
    logic [MAP_AW-1:0]      raddr;
  } map_req_t;

endpackage

// ----- hdl/abslc_ram.sv -----
`timescale 1ns / 1ps

module abslc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/abslc_front.sv -----
`timescale 1ns / 1ps

module abslc_front
  import abslc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   take_ok_i,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [LEVEL_W-1:0]     level_select_i,
  input  logic [BAND_W-1:0]      entry_index_i,
  input  logic [OUTPUT_BITS-1:0] entry_value_i,
  output map_req_t               map_req_o,
  output logic                   meas_load_o,
  output meas_t                  meas_o
);

  logic [THR_W-1:0]       thr_q [NUM_THR];
  logic [POINTS_W-1:0]    points_q;
  logic [LEVEL_W-1:0]     menu_level_q, menu_level_d;
  logic [MENU_LEVELS-1:0] row_present_q, row_present_d;

  logic [POINTS_W-1:0]    eff_points;
  logic                   accept;
  logic                   is_measure;
  logic                   force_jump;
  logic                   do_write;
  logic [LEVEL_W-1:0]     meas_level;
  logic [LVL_EXT_W-1:0]   meas_level_ext;
  logic [LVL_EXT_W-1:0]   wr_level_ext;
  logic                   meas_in_range;
  logic                   wr_in_range;
  logic                   meas_row_ok;
  logic [BAND_W-1:0]      band;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THR; i++) begin
        thr_q[i] <= '0;
      end
      points_q <= POINTS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i) inside
        CFG_THR0, CFG_THR1, CFG_THR2, CFG_THR3: begin
          thr_q[cfg_index_i[1:0]] <= cfg_data_i;
        end
        CFG_POINTS: begin
          points_q <= cfg_data_i[POINTS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign eff_points = (points_q > POINTS_W'(MAX_POINTS)) ? POINTS_W'(MAX_POINTS) : points_q;
  assign accept     = in_valid_i && take_ok_i;

  always_comb begin
    is_measure = 1'b0;
    force_jump = 1'b0;
    do_write   = 1'b0;
    unique case (action_e'(action_i))
      ACT_TICK: begin
        is_measure = 1'b1;
      end
      ACT_LEVEL: begin
        is_measure = 1'b1;
        force_jump = 1'b1;
      end
      ACT_WRITE: begin
        do_write = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // first threshold above the sample
  always_comb begin
    band = eff_points;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if ((BAND_W'(i) < eff_points) && (THR_W'(sample_i) < thr_q[i])) begin
        band = BAND_W'(i);
      end
    end
  end

  assign meas_level     = force_jump ? level_select_i : menu_level_q;
  assign meas_level_ext = LVL_EXT_W'(meas_level);
  assign wr_level_ext   = LVL_EXT_W'(level_select_i);
  assign meas_in_range  = meas_level_ext < LVL_EXT_W'(MENU_LEVELS);
  assign wr_in_range    = (wr_level_ext < LVL_EXT_W'(MENU_LEVELS))
                          && (entry_index_i <= BAND_W'(MAX_POINTS));
  assign meas_row_ok    = meas_in_range && row_present_q[meas_level_ext[LVL_IDX_W-1:0]];

  always_comb begin
    menu_level_d  = menu_level_q;
    row_present_d = row_present_q;
    if (accept && force_jump) begin
      menu_level_d = level_select_i;
    end
    if (accept && do_write && wr_in_range && (entry_index_i == eff_points)) begin
      row_present_d[wr_level_ext[LVL_IDX_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_level_q  <= MENU_LEVEL_RESET;
      row_present_q <= '0;
    end else begin
      menu_level_q  <= menu_level_d;
      row_present_q <= row_present_d;
    end
  end

  assign map_req_o.we    = accept && do_write && wr_in_range;
  assign map_req_o.waddr = MAP_AW'(wr_level_ext[LVL_IDX_W-1:0]) * MAP_AW'(ROW_LEN)
                           + MAP_AW'(entry_index_i);
  assign map_req_o.wdata = entry_value_i;
  assign map_req_o.re    = meas_load_o;
  assign map_req_o.raddr = MAP_AW'(meas_level_ext[LVL_IDX_W-1:0]) * MAP_AW'(ROW_LEN)
                           + MAP_AW'(band);

  assign meas_load_o      = accept && is_measure && meas_row_ok;
  assign meas_o.force_jump = force_jump;
  assign meas_o.band       = band;
  assign meas_o.level      = meas_level;

endmodule

// ----- hdl/abslc_slew.sv -----
`timescale 1ns / 1ps

`include "ambient_backlight_slew_control_top_assert.svh"

module abslc_slew
  import abslc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   meas_load_i,
  input  meas_t                  meas_i,
  input  logic [OUTPUT_BITS-1:0] map_rdata_i,
  output logic                   take_ok_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUTPUT_BITS-1:0] brightness_o,
  output logic [OUTPUT_BITS-1:0] target_brightness_o,
  output logic [BAND_W-1:0]      band_o,
  output logic [LEVEL_W-1:0]     active_level_o
);

  logic                   s1_valid_q, s1_valid_d;
  meas_t                  s1_meas_q;
  logic                   out_valid_q, out_valid_d;
  logic [OUTPUT_BITS-1:0] cur_q, cur_d;
  logic [OUTPUT_BITS-1:0] bright_q, target_q;
  logic [BAND_W-1:0]      band_q;
  logic [LEVEL_W-1:0]     level_q;
  logic                   s1_advance;
  logic [OUTPUT_BITS-1:0] target;

  assign target     = map_rdata_i;
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign take_ok_o  = !s1_valid_q || s1_advance;

  always_comb begin
    cur_d = cur_q;
    if (target < cur_q) begin
      cur_d = s1_meas_q.force_jump ? target : cur_q - OUTPUT_BITS'(1);
    end else if (target > cur_q) begin
      cur_d = s1_meas_q.force_jump ? target : cur_q + OUTPUT_BITS'(1);
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
    if (meas_load_i) begin
      s1_valid_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_advance) begin
        cur_q <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_load_i) begin
      s1_meas_q <= meas_i;
    end
    if (s1_advance) begin
      bright_q <= cur_d;
      target_q <= target;
      band_q   <= s1_meas_q.band;
      level_q  <= s1_meas_q.level;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign brightness_o        = bright_q;
  assign target_brightness_o = target_q;
  assign band_o              = band_q;
  assign active_level_o      = level_q;

  `ABSLC_ASSERT(a_jump_hits_target, s1_advance && s1_meas_q.force_jump |=> bright_q == target_q, "forced jump missed target")
  `ABSLC_ASSERT(a_cur_tracks_out, s1_advance |=> cur_q == bright_q, "brightness state and result disagree")
  `ABSLC_ASSERT(a_held_item_kept, s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q, "stalled request dropped")

endmodule

// ----- hdl/ambient_backlight_slew_control_top.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                  payload
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in   in_valid_i / in_ready_o    action, sample, level_select, entry_index/value
// out       out  out_valid_o / out_ready_i  brightness, target_brightness, band, active_level
//
// one request per cycle while out_ready_i does not stall the output
// map read at the accepting edge; the slew (step or jump) then loads the result register
// reset zeroes thresholds, slew state, row flags; presets points, menu level; not the map
// with out_ready_i low the result holds, one more measure waits, then in_ready_o drops
// cfg_ready_o is always high

module ambient_backlight_slew_control_top
  import abslc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [LEVEL_W-1:0]     level_select_i,
  input  logic [BAND_W-1:0]      entry_index_i,
  input  logic [OUTPUT_BITS-1:0] entry_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUTPUT_BITS-1:0] brightness_o,
  output logic [OUTPUT_BITS-1:0] target_brightness_o,
  output logic [BAND_W-1:0]      band_o,
  output logic [LEVEL_W-1:0]     active_level_o
);

  map_req_t               map_req;
  logic                   meas_load;
  meas_t                  meas;
  logic [OUTPUT_BITS-1:0] map_rdata;
  logic                   take_ok;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = take_ok;

  abslc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .take_ok_i      (take_ok),
    .action_i       (action_i),
    .sample_i       (sample_i),
    .level_select_i (level_select_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .map_req_o      (map_req),
    .meas_load_o    (meas_load),
    .meas_o         (meas)
  );

  abslc_ram #(
    .WIDTH (OUTPUT_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_req.we),
    .waddr_i (map_req.waddr),
    .wdata_i (map_req.wdata),
    .re_i    (map_req.re),
    .raddr_i (map_req.raddr),
    .rdata_o (map_rdata)
  );

  abslc_slew u_slew (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .meas_load_i         (meas_load),
    .meas_i              (meas),
    .map_rdata_i         (map_rdata),
    .take_ok_o           (take_ok),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .brightness_o        (brightness_o),
    .target_brightness_o (target_brightness_o),
    .band_o              (band_o),
    .active_level_o      (active_level_o)
  );

endmodule
